// ===== rtl/four_digit_seven_segment_scanner_assert.svh =====
// Assertion macros used by the scanner's top module.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdss_pkg.sv =====
package fdss_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int NUM_W   = 14;
  localparam int POINT_W = 3;
  localparam int WORD_W  = 2;
  localparam int MASK_W  = 4;
  localparam int SEG_W   = 8;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_NUMBER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WORD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Word selections
  localparam logic [WORD_W-1:0] WORD_CURRENT = 2'd0;
  localparam logic [WORD_W-1:0] WORD_VOLTAGE = 2'd1;
  localparam logic [WORD_W-1:0] WORD_POWER   = 2'd2;

  // Reciprocal of ten for 14-bit values: q = (x * RECIP_TEN) >> RECIP_SHIFT
  localparam int                RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_TEN  = 17'd52429;
  localparam int                RECIP_SHIFT = 19;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [NUM_W-1:0]   number;
    logic [POINT_W-1:0] point;
    logic [WORD_W-1:0]  word;
  } fdss_entry_t;

  typedef struct packed {
    logic        valid;
    fdss_entry_t entry;
  } fdss_head_t;

  // Segment pattern of one decimal digit (point bit clear)
  function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // One byte of a fixed word, digit i from the least significant end
  function automatic logic [SEG_W-1:0] word_byte(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] i);
    logic [SEG_W-1:0] p;
    p = 8'h00;
    unique case (w)
      WORD_CURRENT: begin
        unique case (i)
          2'd0: p = 8'h78;
          2'd1: p = 8'h37;
          2'd2: p = 8'h31;
          default: p = 8'h39;
        endcase
      end
      WORD_VOLTAGE: begin
        unique case (i)
          2'd0: p = 8'h78;
          2'd1: p = 8'h38;
          2'd2: p = 8'h3F;
          default: p = 8'h3E;
        endcase
      end
      WORD_POWER: begin
        unique case (i)
          2'd0: p = 8'h1E;
          2'd1: p = 8'h3C;
          2'd2: p = 8'h3F;
          default: p = 8'h73;
        endcase
      end
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/fdss_chan_if.sv =====
interface fdss_in_if import fdss_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [NUM_W-1:0]   number_value;
  logic [POINT_W-1:0] point_position;
  logic [WORD_W-1:0]  word_select;

  modport source (output valid, command, number_value, point_position, word_select,
                  input ready);
  modport sink   (input valid, command, number_value, point_position, word_select,
                  output ready);
endinterface

interface fdss_out_if import fdss_pkg::*;;
  logic              valid;
  logic              ready;
  logic              serial_bit;
  logic              shift_clock;
  logic              latch_clock;
  logic [MASK_W-1:0] digit_off_mask;
  logic              last;

  modport source (output valid, serial_bit, shift_clock, latch_clock, digit_off_mask, last,
                  input ready);
  modport sink   (input valid, serial_bit, shift_clock, latch_clock, digit_off_mask, last,
                  output ready);
endinterface

// ===== rtl/fdss_front.sv =====
module fdss_front import fdss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fdss_in_if.sink    in_ch,
  input  logic       pop_i,
  output fdss_head_t head_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fdss_entry_t        ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r;
  logic [PTR_W-1:0]   rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               keep;
  logic               push;
  fdss_entry_t        ent_in;

  // Classify: drop unknown commands and unknown words
  always_comb begin
    unique case (in_ch.command) inside
      CMD_NUMBER, CMD_TICK: keep = 1'b1;
      CMD_WORD:             keep = in_ch.word_select inside
                                   {WORD_CURRENT, WORD_VOLTAGE, WORD_POWER};
      default:              keep = 1'b0;
    endcase
  end

  assign ent_in.op     = in_ch.command;
  assign ent_in.number = in_ch.number_value;
  assign ent_in.point  = in_ch.point_position;
  assign ent_in.word   = in_ch.word_select;

  assign in_ch.ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready && keep;

  assign head_o.valid = (cnt_r != '0);
  assign head_o.entry = ent_r[rd_r];

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop_i) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop_i);
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= ent_in;
    end
  end

endmodule

// ===== rtl/fdss_back.sv =====
module fdss_back import fdss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fdss_head_t head_i,
  output logic       pop_o,
  fdss_out_if.source out_ch
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);
  localparam int EXT_W = DIGIT_COUNT + MASK_W;
  localparam int PROD_W = NUM_W + RECIP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIGIT = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_LATCH = 3'd3;
  localparam logic [2:0] ST_SHOW  = 3'd4;

  logic [2:0]             state_r;
  logic [SEG_W-1:0]       pat_r [DIGIT_COUNT];
  logic [NUM_W-1:0]       rem_r;
  logic [POINT_W-1:0]     point_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       scan_r;
  logic [DIGIT_COUNT-1:0] en_r;
  logic [SEG_W-1:0]       sh_r;
  logic [2:0]             cnt_r;

  logic                   ovalid_r;
  logic                   obit_r;
  logic                   oshift_r;
  logic                   olatch_r;
  logic [MASK_W-1:0]      omask_r;
  logic                   olast_r;

  logic                   slot_free;
  logic                   emit;
  logic [PROD_W-1:0]      prod;
  logic [NUM_W-1:0]       quot;
  logic [NUM_W+2:0]       tens;
  logic [3:0]             digit;
  logic                   point_here;
  logic [DIGIT_COUNT-1:0] en_show;
  logic [EXT_W-1:0]       cur_ext;
  logic [EXT_W-1:0]       off_ext;
  logic [EXT_W-1:0]       show_ext;

  assign slot_free = !ovalid_r || out_ch.ready;
  assign pop_o     = (state_r == ST_IDLE) && head_i.valid;
  assign emit      = slot_free && ((state_r == ST_SHIFT) || (state_r == ST_LATCH) ||
                                   (state_r == ST_SHOW));

  // Peel off the least significant decimal digit
  assign prod       = PROD_W'(rem_r) * PROD_W'(RECIP_TEN);
  assign quot       = NUM_W'(prod >> RECIP_SHIFT);
  assign tens       = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign digit      = 4'(rem_r - NUM_W'(tens));
  assign point_here = (point_r == POINT_W'(idx_r));

  // Enable pattern with only the scanned digit lit
  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      en_show[k] = (IDX_W'(DIGIT_COUNT - 1 - k) != scan_r);
    end
  end

  assign cur_ext  = EXT_W'(en_r);
  assign off_ext  = EXT_W'({DIGIT_COUNT{1'b1}});
  assign show_ext = EXT_W'(en_show);

  // Sequencer: loads, digit split and tick output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      scan_r   <= '0;
      en_r     <= '1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        pat_r[i] <= '0;
      end
    end else begin
      // present a new item or drop the one taken
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head_i.valid) begin
            unique case (head_i.entry.op)
              CMD_NUMBER: begin
                rem_r   <= head_i.entry.number;
                point_r <= head_i.entry.point;
                idx_r   <= '0;
                state_r <= ST_DIGIT;
              end
              CMD_WORD: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pat_r[i] <= (i < 4) ? word_byte(head_i.entry.word, 2'(i)) : '0;
                end
              end
              CMD_TICK: begin
                sh_r    <= pat_r[scan_r];
                cnt_r   <= '0;
                state_r <= ST_SHIFT;
              end
              default: ;
            endcase
          end
        end
        ST_DIGIT: begin
          pat_r[idx_r] <= seg_digit(digit) | {point_here, 7'b0000000};
          rem_r        <= quot;
          idx_r        <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (slot_free) begin
            obit_r   <= sh_r[SEG_W-1];
            oshift_r <= 1'b1;
            olatch_r <= 1'b0;
            omask_r  <= cur_ext[MASK_W-1:0];
            olast_r  <= 1'b0;
            sh_r     <= sh_r << 1;
            cnt_r    <= cnt_r + 1'b1;
            if (cnt_r == 3'd7) begin
              state_r <= ST_LATCH;
            end
          end
        end
        ST_LATCH: begin
          // serial bit keeps the last level shifted
          if (slot_free) begin
            oshift_r <= 1'b0;
            olatch_r <= 1'b1;
            omask_r  <= off_ext[MASK_W-1:0];
            olast_r  <= 1'b0;
            en_r     <= '1;
            state_r  <= ST_SHOW;
          end
        end
        ST_SHOW: begin
          if (slot_free) begin
            oshift_r <= 1'b0;
            olatch_r <= 1'b0;
            omask_r  <= show_ext[MASK_W-1:0];
            olast_r  <= 1'b1;
            en_r     <= en_show;
            scan_r   <= (scan_r == LAST_IDX) ? '0 : scan_r + 1'b1;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.serial_bit     = obit_r;
  assign out_ch.shift_clock    = oshift_r;
  assign out_ch.latch_clock    = olatch_r;
  assign out_ch.digit_off_mask = omask_r;
  assign out_ch.last           = olast_r;

endmodule

// ===== rtl/four_digit_seven_segment_scanner.sv =====
// Multiplexed seven-segment driver for an external 8-bit shift register with a
// storage latch and active-low digit enables. Load-number items store the
// segment patterns of DIGIT_COUNT decimal digits (least significant first,
// leading zeros shown, point on the chosen digit); load-word items store a
// fixed word; scan ticks give ten items each: eight shift items MSB first, a
// latch item with all digits off, then one item that lights the next digit in
// round-robin order. A two-entry queue between the command front and the
// sequencer lets input keep flowing while results wait. A tick sends its
// results through the single output register, a load-number splits one digit
// per cycle through the divide-by-ten multiplier, and a load-word writes all of
// its patterns together. Unknown commands and word codes are accepted and dropped.
`include "four_digit_seven_segment_scanner_assert.svh"

module four_digit_seven_segment_scanner import fdss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  fdss_in_if.sink    in_ch,
  fdss_out_if.source out_ch
);

  fdss_head_t head;
  logic       pop;

  // Accept and classify items
  fdss_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .pop_i  (pop),
    .head_o (head)
  );

  // Carry out loads and scan ticks
  fdss_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

  // Result sequence checks
  `FDSS_ASSERT_NOW(a_clock_excl, clk, rst_n, out_ch.valid, !(out_ch.shift_clock && out_ch.latch_clock), "shift and latch pulse together")
  `FDSS_ASSERT_NOW(a_last_quiet, clk, rst_n, out_ch.valid && out_ch.last, !out_ch.shift_clock && !out_ch.latch_clock, "final item pulses a clock")
  `FDSS_ASSERT_NEXT(a_latch_show, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.latch_clock, out_ch.valid && out_ch.last, "latch not followed by digit enable")

endmodule
